>>> src/rvdc_pkg.sv
// Package for the RV32I decode stage: word types, opcodes and operation codes.
package rvdc_pkg;

  typedef struct packed {
    logic [31:0] instruction;
    logic [31:0] pc_current;
    logic [31:0] rs1_value;
    logic [31:0] rs2_value;
  } dec_in_t;

  typedef struct packed {
    logic [4:0]  rs1_addr;
    logic [4:0]  rs2_addr;
    logic [4:0]  rd_addr;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [31:0] store_data;
    logic [31:0] target_addr;
    logic [3:0]  alu_op;
    logic [1:0]  result_select;
    logic [1:0]  access_size;
    logic [6:0]  flags;
  } dec_out_t;

  localparam logic [6:0] OPC_REG    = 7'b0110011;
  localparam logic [6:0] OPC_IMM    = 7'b0010011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_FENCE  = 7'b0001111;

  localparam logic [6:0] FUNCT7_ZERO = 7'b0000000;
  localparam logic [6:0] FUNCT7_ALT  = 7'b0100000;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // Load and store widths; stores use only the first three.
  localparam logic [2:0] F3_MEM_B  = 3'd0;
  localparam logic [2:0] F3_MEM_H  = 3'd1;
  localparam logic [2:0] F3_MEM_W  = 3'd2;
  localparam logic [2:0] F3_MEM_BU = 3'd4;
  localparam logic [2:0] F3_MEM_HU = 3'd5;

  // The only funct3 that jalr and fence accept.
  localparam logic [2:0] F3_ZERO = 3'd0;

  localparam logic [3:0] ALU_NONE = 4'd0;
  localparam logic [3:0] ALU_ADD  = 4'd1;
  localparam logic [3:0] ALU_SUB  = 4'd2;
  localparam logic [3:0] ALU_OR   = 4'd3;
  localparam logic [3:0] ALU_AND  = 4'd4;
  localparam logic [3:0] ALU_XOR  = 4'd5;
  localparam logic [3:0] ALU_SLL  = 4'd6;
  localparam logic [3:0] ALU_SRL  = 4'd7;
  localparam logic [3:0] ALU_SRA  = 4'd8;
  localparam logic [3:0] ALU_SLT  = 4'd9;
  localparam logic [3:0] ALU_SLTU = 4'd10;

  localparam logic [1:0] RSEL_ALU  = 2'd0;
  localparam logic [1:0] RSEL_LOAD = 2'd1;
  localparam logic [1:0] RSEL_LINK = 2'd2;

  localparam logic [1:0] SIZE_WORD = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_BYTE = 2'd2;

  localparam int FLAG_MEMWRITE = 0;
  localparam int FLAG_MEMREAD  = 1;
  localparam int FLAG_REGWRITE = 2;
  localparam int FLAG_BRANCH   = 3;
  localparam int FLAG_TAKEN    = 4;
  localparam int FLAG_ILLEGAL  = 5;
  localparam int FLAG_UNSIGNED = 6;

  // ALU operation for the non-alternate funct7 encodings, indexed by funct3.
  function automatic logic [3:0] plain_alu_op(input logic [2:0] f3);
    logic [3:0] op;
    unique case (f3)
      F3_ADD:  op = ALU_ADD;
      F3_SLL:  op = ALU_SLL;
      F3_SLT:  op = ALU_SLT;
      F3_SLTU: op = ALU_SLTU;
      F3_XOR:  op = ALU_XOR;
      F3_SR:   op = ALU_SRL;
      F3_OR:   op = ALU_OR;
      F3_AND:  op = ALU_AND;
      default: op = ALU_NONE;
    endcase
    return op;
  endfunction

  // Access size code from the funct3 field of a load or store.
  function automatic logic [1:0] access_size_code(input logic [2:0] f3);
    logic [1:0] sz;
    unique case (f3)
      F3_MEM_W:            sz = SIZE_WORD;
      F3_MEM_H, F3_MEM_HU: sz = SIZE_HALF;
      default:             sz = SIZE_BYTE;
    endcase
    return sz;
  endfunction

endpackage

>>> src/rv32i_decode_control.sv
// RV32I decode stage: input register, decode logic and result register.
//
// Usage: the fetch side presents one word per cycle on req (instruction, pc
// and the two register file read values) with req_valid; it is taken at an
// edge where req_valid and req_ready are both high. Each word yields exactly
// one decoded word on rsp, taken at an edge where rsp_valid and rsp_ready
// are both high.
// Path: a word taken on req passes through the input register, then the
// decode logic into the result register, before it appears on rsp.
// Throughput: one word per cycle while rsp_ready is high, set by the
// two-register pipeline; the decode itself is a single pass of shallow
// logic plus three 32-bit adders and the branch comparators.
// Stall: when rsp_ready is low the result register holds its word; the
// input register still fills if empty, so up to two words are held before
// req_ready drops.
// Reset: rst (synchronous) empties both registers; no word is output.
module rv32i_decode_control
  import rvdc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  dec_in_t  req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output dec_out_t rsp
);

  logic     stage_valid;
  dec_in_t  stage;
  logic     advance;
  dec_out_t dec_next;

  assign advance   = stage_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (req_ready) begin
      stage_valid <= req_valid;
    end
    if (req_valid && req_ready) begin
      stage <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!rsp_valid || rsp_ready) begin
      rsp_valid <= stage_valid;
    end
    if (advance) begin
      rsp <= dec_next;
    end
  end

  always_comb begin
    logic [31:0] ins;
    logic [31:0] pc;
    logic [31:0] r1;
    logic [31:0] r2;
    logic [6:0]  opc;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] jalr_sum;
    logic        taken;
    logic        bad;

    ins = stage.instruction;
    pc  = stage.pc_current;
    r1  = stage.rs1_value;
    r2  = stage.rs2_value;
    opc = ins[6:0];
    f3  = ins[14:12];
    f7  = ins[31:25];

    imm_i = {{20{ins[31]}}, ins[31:20]};
    imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
    imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
    imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
    jalr_sum = r1 + imm_i;

    unique case (f3)
      F3_BEQ:  taken = (r1 == r2);
      F3_BNE:  taken = (r1 != r2);
      F3_BLT:  taken = ($signed(r1) < $signed(r2));
      F3_BGE:  taken = ($signed(r1) >= $signed(r2));
      F3_BLTU: taken = (r1 < r2);
      F3_BGEU: taken = (r1 >= r2);
      default: taken = 1'b0;
    endcase

    dec_next = '0;
    bad      = 1'b0;

    unique case (opc)
      OPC_REG: begin
        if (f7 == FUNCT7_ZERO) begin
          dec_next.alu_op = plain_alu_op(f3);
        end else if (f7 == FUNCT7_ALT && (f3 == F3_ADD || f3 == F3_SR)) begin
          dec_next.alu_op = (f3 == F3_ADD) ? ALU_SUB : ALU_SRA;
        end else begin
          bad = 1'b1;
        end
        dec_next.rs1_addr  = ins[19:15];
        dec_next.rs2_addr  = ins[24:20];
        dec_next.rd_addr   = ins[11:7];
        dec_next.operand_a = r1;
        dec_next.operand_b = r2;
        dec_next.flags[FLAG_REGWRITE] = 1'b1;
      end
      OPC_IMM: begin
        // Shift immediates only allow the plain funct7, or the alternate one for sra.
        if (f3 == F3_SLL) begin
          bad = (f7 != FUNCT7_ZERO);
        end else if (f3 == F3_SR) begin
          bad = (f7 != FUNCT7_ZERO) && (f7 != FUNCT7_ALT);
        end
        if (f3 == F3_SR && f7 == FUNCT7_ALT) begin
          dec_next.alu_op = ALU_SRA;
        end else begin
          dec_next.alu_op = plain_alu_op(f3);
        end
        dec_next.rs1_addr  = ins[19:15];
        dec_next.rd_addr   = ins[11:7];
        dec_next.operand_a = r1;
        dec_next.operand_b = imm_i;
        dec_next.flags[FLAG_REGWRITE] = 1'b1;
      end
      OPC_LOAD: begin
        bad = !(f3 inside {F3_MEM_B, F3_MEM_H, F3_MEM_W, F3_MEM_BU, F3_MEM_HU});
        dec_next.rs1_addr      = ins[19:15];
        dec_next.rd_addr       = ins[11:7];
        dec_next.operand_a     = r1;
        dec_next.operand_b     = imm_i;
        dec_next.alu_op        = ALU_ADD;
        dec_next.result_select = RSEL_LOAD;
        dec_next.access_size   = access_size_code(f3);
        dec_next.flags[FLAG_REGWRITE] = 1'b1;
        dec_next.flags[FLAG_MEMREAD]  = 1'b1;
        dec_next.flags[FLAG_UNSIGNED] = f3[2];
      end
      OPC_STORE: begin
        bad = (f3 > F3_MEM_W);
        dec_next.rs1_addr    = ins[19:15];
        dec_next.rs2_addr    = ins[24:20];
        dec_next.operand_a   = r1;
        dec_next.operand_b   = imm_s;
        dec_next.store_data  = r2;
        dec_next.alu_op      = ALU_ADD;
        dec_next.access_size = access_size_code(f3);
        dec_next.flags[FLAG_MEMWRITE] = 1'b1;
      end
      OPC_BRANCH: begin
        bad = !(f3 inside {F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU});
        dec_next.rs1_addr    = ins[19:15];
        dec_next.rs2_addr    = ins[24:20];
        dec_next.operand_a   = r1;
        dec_next.operand_b   = r2;
        dec_next.target_addr = pc + imm_b;
        dec_next.flags[FLAG_BRANCH] = 1'b1;
        dec_next.flags[FLAG_TAKEN]  = taken;
      end
      OPC_LUI, OPC_AUIPC: begin
        dec_next.rd_addr   = ins[11:7];
        dec_next.operand_a = {ins[31:12], 12'h000};
        dec_next.operand_b = (opc == OPC_AUIPC) ? pc : 32'h0;
        dec_next.alu_op    = ALU_ADD;
        dec_next.flags[FLAG_REGWRITE] = 1'b1;
      end
      OPC_JAL: begin
        dec_next.rd_addr       = ins[11:7];
        dec_next.operand_a     = pc;
        dec_next.target_addr   = pc + imm_j;
        dec_next.result_select = RSEL_LINK;
        dec_next.flags[FLAG_REGWRITE] = 1'b1;
        dec_next.flags[FLAG_TAKEN]    = 1'b1;
      end
      OPC_JALR: begin
        bad = (f3 != F3_ZERO);
        dec_next.rs1_addr      = ins[19:15];
        dec_next.rd_addr       = ins[11:7];
        dec_next.operand_a     = pc;
        dec_next.target_addr   = {jalr_sum[31:1], 1'b0};
        dec_next.result_select = RSEL_LINK;
        dec_next.flags[FLAG_REGWRITE] = 1'b1;
        dec_next.flags[FLAG_TAKEN]    = 1'b1;
      end
      OPC_FENCE: begin
        bad = (f3 != F3_ZERO);
      end
      default: begin
        bad = 1'b1;
      end
    endcase

    // An illegal word reports only the illegal flag.
    if (bad) begin
      dec_next = '0;
      dec_next.flags[FLAG_ILLEGAL] = 1'b1;
    end
  end

  a_illegal_clean: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && rsp.flags[FLAG_ILLEGAL] |->
        rsp.flags == 7'h20 && rsp.target_addr == 32'h0 && rsp.alu_op == ALU_NONE)
    else $error("illegal word carries more than the illegal flag");

  a_mem_exclusive: assert property (@(posedge clk) disable iff (rst)
      rsp_valid |-> !(rsp.flags[FLAG_MEMWRITE] && rsp.flags[FLAG_MEMREAD]))
    else $error("word both reads and writes memory");

  a_store_data_only_on_store: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && !rsp.flags[FLAG_MEMWRITE] |-> rsp.store_data == 32'h0)
    else $error("store data set on a non-store word");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
      req_valid && req_ready |=> stage_valid)
    else $error("accepted word did not reach the input register");

  a_stage_held: assert property (@(posedge clk) disable iff (rst)
      stage_valid && !advance |=> stage_valid && $stable(stage))
    else $error("input register lost a word while the result side stalled");

endmodule
